[hw/rtl/bdq_pkg.sv]
// Shared types and constants for the bounded double-ended queue.
`timescale 1ns / 1ps

package bdq_pkg;

    localparam int CAP_W = 11;
    localparam int OCC_W = 11;
    localparam int WORD_W = 32;
    localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

    typedef enum logic [2:0] {
        MODE_PUSH_FRONT = 3'd0,
        MODE_PUSH_REAR  = 3'd1,
        MODE_POP_FRONT  = 3'd2,
        MODE_POP_REAR   = 3'd3,
        MODE_QUERY      = 3'd4
    } mode_t;

    typedef struct packed {
        logic [2:0]               mode;
        logic signed [WORD_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic                     ok;
        logic signed [WORD_W-1:0] front_value;
        logic signed [WORD_W-1:0] rear_value;
        logic                     is_empty;
        logic                     is_full;
        logic [OCC_W-1:0]         occupancy;
    } out_item_t;

    typedef struct packed {
        logic accept;
        logic load;
    } bdq_cmd_t;

endpackage

[hw/rtl/bdq_ctrl.sv]
// Controller state machine: input acceptance, result loading and output valid.
`timescale 1ns / 1ps

module bdq_ctrl
    import bdq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    output logic     item_stall,
    output logic     result_valid,
    input  logic     result_stall,
    output bdq_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_LOAD = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   result_valid_reg;
    logic   result_valid_next;

    always_comb
    begin
        cmd.accept = 1'b0;
        cmd.load = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    cmd.load = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    assign item_stall = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;

    a_accept_then_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> (state_reg == ST_LOAD))
        else $error("accepted transfer did not move to the load state");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD && result_valid_reg && result_stall)
            |=> (state_reg == ST_LOAD && result_valid_reg))
        else $error("pending result was overwritten while stalled");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_stall) |=> result_valid_reg)
        else $error("stalled result transfer was dropped");

endmodule

[hw/rtl/bdq_datapath.sv]
// Datapath: ring store, head and count registers, capacity and result register.
`timescale 1ns / 1ps

module bdq_datapath
    import bdq_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int DATA_WIDTH = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  bdq_cmd_t         cmd,
    input  in_item_t         item,
    input  logic             cfg_wr_en,
    input  logic [CAP_W-1:0] cfg_wr_data,
    output out_item_t        result
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;
    localparam int MW = (CW > CAP_W) ? CW : CAP_W;
    localparam int XW = (DATA_WIDTH > WORD_W) ? DATA_WIDTH : WORD_W;
    localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
    localparam logic [MW-1:0] DEPTH_M = MW'(DEPTH);
    localparam logic [AW-1:0] LAST_POS = AW'(DEPTH - 1);

    logic [DATA_WIDTH-1:0] ring_mem [DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    logic [AW-1:0]         head_reg;
    logic [AW-1:0]         head_next;
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    logic [CAP_W-1:0]      cap_reg;
    logic [2:0]            op_reg;
    logic                  ok_reg;
    logic                  ok_next;
    logic [DATA_WIDTH-1:0] val_reg;
    logic [DATA_WIDTH-1:0] front_reg;
    logic [DATA_WIDTH-1:0] front_next;
    logic [DATA_WIDTH-1:0] rear_reg;
    logic [DATA_WIDTH-1:0] rear_next;
    out_item_t             result_reg;

    logic [MW-1:0]         eff_cap;
    logic                  has_room;
    logic                  non_empty;
    logic [DATA_WIDTH-1:0] wr_data;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic [AW-1:0]         head_dec;
    logic [AW-1:0]         head_inc;
    logic [CW-1:0]         offset;
    logic [SW-1:0]         pos_sum;
    logic [AW-1:0]         pos;
    logic [XW-1:0]         front_ext;
    logic [XW-1:0]         rear_ext;
    logic [XW-1:0]         empty_ext;
    logic [DATA_WIDTH-1:0] empty_word;

    assign eff_cap = (MW'(cap_reg) > DEPTH_M) ? DEPTH_M : MW'(cap_reg);
    assign has_room = (MW'(count_reg) < eff_cap);
    assign non_empty = (count_reg != '0);
    assign wr_data = DATA_WIDTH'(XW'($unsigned(item.value)));

    assign head_dec = (head_reg == '0) ? LAST_POS : head_reg - AW'(1);
    assign head_inc = (head_reg == LAST_POS) ? '0 : head_reg + AW'(1);

    // The rear delete reads the entry just before the old rear, which becomes the new rear; all others use the count.
    assign offset = (item.mode == MODE_POP_REAR) ? count_reg - CW'(2) : count_reg;
    assign pos_sum = SW'(head_reg) + SW'(offset);
    assign pos = (pos_sum >= DEPTH_S) ? AW'(pos_sum - DEPTH_S) : AW'(pos_sum);

    always_comb
    begin
        ok_next = 1'b0;
        head_next = head_reg;
        count_next = count_reg;
        wr_en = 1'b0;
        wr_addr = pos;
        rd_en = 1'b0;
        rd_addr = pos;
        unique case (item.mode)
            MODE_PUSH_FRONT:
            begin
                if (has_room)
                begin
                    ok_next = 1'b1;
                    head_next = head_dec;
                    count_next = count_reg + CW'(1);
                    wr_en = cmd.accept;
                    wr_addr = head_dec;
                end
            end
            MODE_PUSH_REAR:
            begin
                if (has_room)
                begin
                    ok_next = 1'b1;
                    count_next = count_reg + CW'(1);
                    wr_en = cmd.accept;
                end
            end
            MODE_POP_FRONT:
            begin
                if (non_empty)
                begin
                    ok_next = 1'b1;
                    head_next = head_inc;
                    count_next = count_reg - CW'(1);
                    rd_en = cmd.accept && (count_reg != CW'(1));
                    rd_addr = head_inc;
                end
            end
            MODE_POP_REAR:
            begin
                if (non_empty)
                begin
                    ok_next = 1'b1;
                    count_next = count_reg - CW'(1);
                    rd_en = cmd.accept && (count_reg != CW'(1));
                end
            end
            MODE_QUERY:
            begin
                ok_next = 1'b1;
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ring_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= ring_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            count_reg <= '0;
            cap_reg <= CAP_RESET;
        end
        else
        begin
            if (cmd.accept)
            begin
                head_reg <= head_next;
                count_reg <= count_next;
            end
            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg <= item.mode;
            ok_reg <= ok_next;
            val_reg <= wr_data;
        end
    end

    always_comb
    begin
        front_next = front_reg;
        rear_next = rear_reg;
        if (ok_reg)
        begin
            case (op_reg)
                MODE_PUSH_FRONT:
                begin
                    front_next = val_reg;
                    if (count_reg == CW'(1))
                    begin
                        rear_next = val_reg;
                    end
                end
                MODE_PUSH_REAR:
                begin
                    rear_next = val_reg;
                    if (count_reg == CW'(1))
                    begin
                        front_next = val_reg;
                    end
                end
                MODE_POP_FRONT:
                begin
                    front_next = rd_data_reg;
                end
                MODE_POP_REAR:
                begin
                    rear_next = rd_data_reg;
                end
                default:
                begin
                    front_next = front_reg;
                end
            endcase
        end
    end

    assign empty_word = '1;
    assign empty_ext = XW'(empty_word);
    assign front_ext = (count_reg == '0) ? empty_ext : XW'(front_next);
    assign rear_ext = (count_reg == '0) ? empty_ext : XW'(rear_next);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            front_reg <= front_next;
            rear_reg <= rear_next;
            result_reg.ok <= ok_reg;
            result_reg.front_value <= front_ext[WORD_W-1:0];
            result_reg.rear_value <= rear_ext[WORD_W-1:0];
            result_reg.is_empty <= (count_reg == '0);
            result_reg.is_full <= (MW'(count_reg) == eff_cap);
            result_reg.occupancy <= OCC_W'(MW'(count_reg));
        end
    end

    assign result = result_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        MW'(count_reg) <= DEPTH_M)
        else $error("entry count exceeds the ring depth");

    a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(head_reg) < 32'(DEPTH))
        else $error("head index outside the ring");

    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.accept |=> ($stable(count_reg) && $stable(head_reg)))
        else $error("queue state changed without an accepted transfer");

endmodule

[hw/rtl/bounded_double_ended_queue.sv]
// Top level of the bounded double-ended queue.
`timescale 1ns / 1ps

// Each accepted item is handled in order: first the head and count are updated and
// the single-port ring memory is read or written, then the result is formed from the
// registered read data. A finished result waits in an output register, so the next
// item is accepted while it is still stalled. The ring memory has no reset; only
// entries that were written are read back. The capacity register resets to 1024 and
// is clamped to DEPTH.
module bounded_double_ended_queue
    import bdq_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int DATA_WIDTH = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  in_item_t         item,
    output logic             result_valid,
    input  logic             result_stall,
    output out_item_t        result,
    input  logic             cfg_wr_en,
    input  logic [CAP_W-1:0] cfg_wr_data
);

    bdq_cmd_t cmd;

    bdq_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cmd          (cmd)
    );

    bdq_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .item        (item),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .result      (result)
    );

endmodule
